### hdl/pps_pkg.sv
// Package for the priority process scheduler: types, codes and sizes.
// No dependencies.
package pps_pkg;
  localparam int unsigned MaxTasksDef = 16;

  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_CREATE = 3'd1;
  localparam logic [2:0] CMD_KILL   = 3'd2;
  localparam logic [2:0] CMD_BLOCK  = 3'd3;
  localparam logic [2:0] CMD_WAKE   = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NORUN    = 3'd3;
  localparam logic [2:0] ST_BLKEMPTY = 3'd4;
  localparam logic [2:0] ST_NOTFOUND = 3'd5;
  localparam logic [2:0] ST_BADCMD   = 3'd6;

  typedef struct packed {
    logic [15:0] ttime;
    logic [7:0]  pri;
    logic [7:0]  id;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DUPR, S_DUPB, S_DECIDE, S_WSRCH, S_WSHIFT,
    S_BSHIFT, S_INSRCH, S_INSHIFT, S_TICK, S_POPSHIFT, S_OUT
  } state_t;
endpackage

### hdl/priority_process_scheduler_unit.sv
// Top level of the priority process scheduler.
// Depends on pps_pkg and pps_list.
// A command walks list entries: each duplicate check, search and shift steps
// through one entry of a list memory at a time, and in_tready stays low until
// the command's result is loaded for output.
module priority_process_scheduler_unit #(
  parameter int unsigned MaxTasks = pps_pkg::MaxTasksDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // cmd[2:0] proc_id[10:3] new_priority[18:11] new_time[34:19]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata  // status, running_valid, running_id, running_priority,
                                 // running_time_left, terminated_valid, terminated_id,
                                 // ready_count, blocked_count
);
  import pps_pkg::*;
  localparam int unsigned AW = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam int unsigned LW = $clog2(MaxTasks + 1);

  state_t state_r, state_nxt;
  logic [2:0]  cmd_r, cmd_nxt, status_r, status_nxt;
  logic [7:0]  pid_r, pid_nxt;
  entry_t      ins_r, ins_nxt;           // entry to insert into ready list
  entry_t      run_r, run_nxt;
  logic        runf_r, runf_nxt;
  logic        term_r, term_nxt;
  logic [7:0]  tid_r, tid_nxt;
  logic [LW-1:0] rlen_r, rlen_nxt, blen_r, blen_nxt;
  logic [LW-1:0] idx_r, idx_nxt, pos_r, pos_nxt;
  logic        rdv_r, rdv_nxt;          // read data valid for the last issued read address
  logic        tickins_r, tickins_nxt;  // insert belongs to tick phase
  logic        out_v_r;
  logic [55:0] out_d_r, out_d_nxt;
  logic        out_load;

  logic          r_we, b_we;
  logic [AW-1:0] r_wa, r_ra, b_wa, b_ra;
  entry_t        r_wd, b_wd, r_rd, b_rd;

  pps_list #(.Depth(MaxTasks), .AW(AW)) u_ready (
    .clk(clk), .we(r_we), .waddr(r_wa), .wdata(r_wd), .raddr(r_ra), .rdata(r_rd));
  pps_list #(.Depth(MaxTasks), .AW(AW)) u_blocked (
    .clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

  logic [LW:0] total;
  assign total = {1'b0, rlen_r} + {1'b0, blen_r} + {{LW{1'b0}}, runf_r};

  always_comb begin
    entry_t mk;
    state_nxt = state_r; cmd_nxt = cmd_r; status_nxt = status_r; pid_nxt = pid_r;
    ins_nxt = ins_r; run_nxt = run_r; runf_nxt = runf_r; term_nxt = term_r;
    tid_nxt = tid_r; rlen_nxt = rlen_r; blen_nxt = blen_r; idx_nxt = idx_r;
    pos_nxt = pos_r; rdv_nxt = 1'b0; tickins_nxt = tickins_r; out_load = 1'b0;
    r_we = 1'b0; b_we = 1'b0; r_wa = '0; b_wa = '0; r_wd = ins_r; b_wd = run_r;
    r_ra = idx_r[AW-1:0]; b_ra = idx_r[AW-1:0];
    mk = '0;
    out_d_nxt = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt = in_tdata[2:0];
          pid_nxt = in_tdata[10:3];
          ins_nxt = '{ttime: in_tdata[34:19], pri: in_tdata[18:11], id: in_tdata[10:3]};
          status_nxt = ST_OK; term_nxt = 1'b0; tid_nxt = '0; tickins_nxt = 1'b0;
          idx_nxt = '0;
          if (in_tdata[2:0] > CMD_WAKE) begin
            status_nxt = ST_BADCMD; state_nxt = S_OUT;
          end else if (in_tdata[2:0] == CMD_CREATE) begin
            state_nxt = (runf_r && run_r.id == in_tdata[10:3]) ? S_DECIDE : S_DUPR;
            if (runf_r && run_r.id == in_tdata[10:3]) status_nxt = ST_DUP;
          end else begin
            state_nxt = S_DECIDE;
          end
        end
      end
      S_DUPR: begin  // walk ready list one entry a cycle
        r_ra = idx_r[AW-1:0];
        if (rdv_r && r_rd.id == pid_r) begin
          status_nxt = ST_DUP; state_nxt = S_DECIDE;
        end else if (idx_r < rlen_r) begin
          idx_nxt = idx_r + 1'b1; rdv_nxt = 1'b1;
        end else begin
          idx_nxt = '0; state_nxt = S_DUPB;
        end
      end
      S_DUPB: begin
        if (rdv_r && b_rd.id == pid_r) begin
          status_nxt = ST_DUP; state_nxt = S_DECIDE;
        end else if (idx_r < blen_r) begin
          idx_nxt = idx_r + 1'b1; rdv_nxt = 1'b1;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        idx_nxt = '0; pos_nxt = '0;
        case (cmd_r)
          CMD_CREATE: begin
            if (status_r == ST_OK && total >= (LW+1)'(MaxTasks)) status_nxt = ST_FULL;
            if (status_r == ST_OK && total < (LW+1)'(MaxTasks)) state_nxt = S_INSRCH;
            else state_nxt = S_TICK;
          end
          CMD_KILL: begin
            if (runf_r) begin
              runf_nxt = 1'b0; run_nxt = '0;
            end else status_nxt = ST_NORUN;
            state_nxt = S_TICK;
          end
          CMD_BLOCK: begin
            if (!runf_r) begin
              status_nxt = ST_NORUN; state_nxt = S_TICK;
            end else if (blen_r < LW'(MaxTasks)) begin
              idx_nxt = blen_r; state_nxt = S_BSHIFT;
            end else begin
              runf_nxt = 1'b0; run_nxt = '0; state_nxt = S_TICK;
            end
          end
          CMD_WAKE: begin
            if (blen_r == '0) begin
              status_nxt = ST_BLKEMPTY; state_nxt = S_TICK;
            end else state_nxt = S_WSRCH;
          end
          default: state_nxt = S_TICK;
        endcase
      end
      S_BSHIFT: begin  // move entries down by one, tail first
        if (idx_r == '0) begin
          b_we = 1'b1; b_wa = '0; b_wd = run_r;
          blen_nxt = blen_r + 1'b1; runf_nxt = 1'b0; run_nxt = '0;
          state_nxt = S_TICK;
        end else if (!rdv_r) begin
          b_ra = AW'(idx_r - 1'b1); rdv_nxt = 1'b1;
        end else begin
          b_we = 1'b1; b_wa = idx_r[AW-1:0]; b_wd = b_rd;
          idx_nxt = idx_r - 1'b1;
        end
      end
      S_WSRCH: begin
        if (rdv_r && b_rd.id == pid_r) begin
          ins_nxt = b_rd; pos_nxt = idx_r - 1'b1; idx_nxt = idx_r;
          state_nxt = S_WSHIFT;
        end else if (idx_r < blen_r) begin
          idx_nxt = idx_r + 1'b1; rdv_nxt = 1'b1;
        end else begin
          status_nxt = ST_NOTFOUND; state_nxt = S_TICK;
        end
      end
      S_WSHIFT: begin  // close the gap at pos_r; idx_r reads the next entry
        if (idx_r >= blen_r) begin
          blen_nxt = blen_r - 1'b1; idx_nxt = '0; pos_nxt = '0;
          state_nxt = S_INSRCH;
        end else if (!rdv_r) begin
          rdv_nxt = 1'b1;
        end else begin
          b_we = 1'b1; b_wa = pos_r[AW-1:0]; b_wd = b_rd;
          pos_nxt = idx_r; idx_nxt = idx_r + 1'b1;
        end
      end
      S_INSRCH: begin  // find first entry with lower priority
        if (rlen_r >= LW'(MaxTasks)) begin
          state_nxt = tickins_r ? S_POPSHIFT : S_TICK;
        end else if (rdv_r && r_rd.pri < ins_r.pri) begin
          pos_nxt = idx_r - 1'b1; idx_nxt = rlen_r; state_nxt = S_INSHIFT;
        end else if (idx_r < rlen_r) begin
          idx_nxt = idx_r + 1'b1; rdv_nxt = 1'b1;
        end else begin
          pos_nxt = rlen_r; idx_nxt = rlen_r; state_nxt = S_INSHIFT;
        end
      end
      S_INSHIFT: begin
        if (idx_r == pos_r) begin
          r_we = 1'b1; r_wa = pos_r[AW-1:0]; r_wd = ins_r;
          rlen_nxt = rlen_r + 1'b1;
          state_nxt = tickins_r ? S_POPSHIFT : S_TICK;
          idx_nxt = '0;
        end else if (!rdv_r) begin
          r_ra = AW'(idx_r - 1'b1); rdv_nxt = 1'b1;
        end else begin
          r_we = 1'b1; r_wa = idx_r[AW-1:0]; r_wd = r_rd;
          idx_nxt = idx_r - 1'b1;
        end
      end
      S_TICK: begin
        idx_nxt = '0;
        if (runf_r) begin
          runf_nxt = 1'b0; run_nxt = '0;
          if (run_r.ttime == '0) begin
            term_nxt = 1'b1; tid_nxt = run_r.id; state_nxt = S_POPSHIFT;
          end else begin
            mk = run_r;
            if (mk.pri != '0) mk.pri = mk.pri - 1'b1;
            ins_nxt = mk; tickins_nxt = 1'b1; pos_nxt = '0; state_nxt = S_INSRCH;
          end
        end else state_nxt = S_POPSHIFT;
      end
      S_POPSHIFT: begin  // idx_r walks; first read yields the head
        if (rlen_r == '0) begin
          state_nxt = S_OUT;
        end else if (!rdv_r) begin
          r_ra = idx_r[AW-1:0]; rdv_nxt = 1'b1;
        end else begin
          if (idx_r == '0) begin
            mk = r_rd;
            if (mk.ttime != '0) mk.ttime = mk.ttime - 1'b1;
            run_nxt = mk; runf_nxt = 1'b1;
          end else begin
            r_we = 1'b1; r_wa = AW'(idx_r - 1'b1); r_wd = r_rd;
          end
          if (idx_r + 1'b1 >= rlen_r) begin
            rlen_nxt = rlen_r - 1'b1; state_nxt = S_OUT;
          end else begin
            idx_nxt = idx_r + 1'b1; r_ra = AW'(idx_r + 1'b1); rdv_nxt = 1'b1;
          end
        end
      end
      S_OUT: begin
        if (!out_v_r || out_tready) begin
          out_load = 1'b1;
          out_d_nxt = {1'b0, 5'(blen_r), 5'(rlen_r), tid_r, term_r,
                       run_r.ttime, run_r.pri, run_r.id, runf_r, status_r};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_DUPR || state_r == S_DUPB || state_r == S_WSRCH ||
        state_r == S_INSRCH) begin
      r_ra = idx_r[AW-1:0]; b_ra = idx_r[AW-1:0];
    end
    if (state_r == S_WSHIFT) b_ra = idx_r[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; runf_r <= 1'b0; run_r <= '0; rlen_r <= '0; blen_r <= '0;
      out_v_r <= 1'b0; rdv_r <= 1'b0; term_r <= 1'b0; tid_r <= '0;
      tickins_r <= 1'b0; idx_r <= '0; pos_r <= '0; status_r <= ST_OK;
    end else begin
      state_r <= state_nxt; runf_r <= runf_nxt; run_r <= run_nxt;
      rlen_r <= rlen_nxt; blen_r <= blen_nxt; rdv_r <= rdv_nxt;
      term_r <= term_nxt; tid_r <= tid_nxt; tickins_r <= tickins_nxt;
      idx_r <= idx_nxt; pos_r <= pos_nxt; status_r <= status_nxt;
      if (out_load) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt; pid_r <= pid_nxt; ins_r <= ins_nxt;
    if (out_load) out_d_r <= out_d_nxt;
  end
endmodule

### hdl/pps_list.sv
// One task list held in a memory with one write port and one registered read port.
// Depends on pps_pkg.
module pps_list #(
  parameter int unsigned Depth = pps_pkg::MaxTasksDef,
  parameter int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  pps_pkg::entry_t    wdata,
  input  logic [AW-1:0]      raddr,
  output pps_pkg::entry_t    rdata
);
  import pps_pkg::*;
  entry_t mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hdl/pps_checker.sv
// Port-level checker for the priority process scheduler, bound to the top.
// Depends on priority_process_scheduler_unit.
module pps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("took two transactions back to back");
  a_run0: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[3] |-> out_tdata[35:4] == 32'd0)
    else $error("running fields set with nothing running");
  a_term0: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[36] |-> out_tdata[44:37] == 8'd0)
    else $error("terminated id set without termination");
endmodule

bind priority_process_scheduler_unit pps_checker u_pps_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata));

### test/tb.sv
// Testbench for priority_process_scheduler_unit: a directed table, then random
// scheduler commands; typed rows are checked against their own result, others
// against a scheduler model held here. Depends on pps_pkg and the scheduler RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pps_pkg::*;

  localparam int unsigned NTasks = MaxTasksDef;
  localparam int unsigned NRand = 500;
  localparam int unsigned CycleLimit = 600000;

  typedef struct packed {
    logic       pad;
    logic [4:0] blocked_count;
    logic [4:0] ready_count;
    logic [7:0] terminated_id;
    logic       terminated_valid;
    logic [15:0] running_time_left;
    logic [7:0] running_priority;
    logic [7:0] running_id;
    logic       running_valid;
    logic [2:0] status;
  } sched_res_t;

  typedef struct {
    logic [2:0]  cmd;
    logic [7:0]  id;
    logic [7:0]  pri;
    logic [15:0] tm;
    bit          typed;
    sched_res_t  res;
  } cmd_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;

  priority_process_scheduler_unit i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready, .out_tdata
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // scheduler model state
  entry_t     rdy_list[NTasks];
  int         rdy_len;
  entry_t     blk_list[NTasks];
  int         blk_len;
  entry_t     run_task;
  bit         run_flag;

  sched_res_t pending_res[$];
  int         mismatches = 0;
  int         n_accepted = 0;
  int         n_results = 0;
  int         cycles = 0;
  bit         tail_phase = 0;

  function automatic void rdy_insert(entry_t e);
    int pos;
    pos = 0;
    if (rdy_len >= NTasks) return;
    while (pos < rdy_len && rdy_list[pos].pri >= e.pri) pos++;
    for (int i = rdy_len; i > pos; i--) rdy_list[i] = rdy_list[i-1];
    rdy_list[pos] = e;
    rdy_len++;
  endfunction

  function automatic bit id_busy(logic [7:0] id);
    if (run_flag && run_task.id == id) return 1;
    for (int i = 0; i < rdy_len; i++) if (rdy_list[i].id == id) return 1;
    for (int i = 0; i < blk_len; i++) if (blk_list[i].id == id) return 1;
    return 0;
  endfunction

  function automatic sched_res_t sched_step(logic [2:0] cmd, logic [7:0] id, logic [7:0] pri,
                                            logic [15:0] tm);
    sched_res_t r;
    entry_t     e;
    bit         found;
    r = '0;
    case (cmd)
      CMD_TICK: r.status = ST_OK;
      CMD_CREATE: begin
        if (id_busy(id)) r.status = ST_DUP;
        else if (rdy_len + blk_len + int'(run_flag) >= NTasks) r.status = ST_FULL;
        else begin
          e.id = id; e.pri = pri; e.ttime = tm;
          rdy_insert(e);
          r.status = ST_OK;
        end
      end
      CMD_KILL: begin
        r.status = run_flag ? ST_OK : ST_NORUN;
        run_flag = 0;
        run_task = '0;
      end
      CMD_BLOCK: begin
        if (!run_flag) r.status = ST_NORUN;
        else begin
          if (blk_len < NTasks) begin
            for (int i = blk_len; i > 0; i--) blk_list[i] = blk_list[i-1];
            blk_list[0] = run_task;
            blk_len++;
          end
          run_flag = 0;
          run_task = '0;
          r.status = ST_OK;
        end
      end
      CMD_WAKE: begin
        if (blk_len == 0) r.status = ST_BLKEMPTY;
        else begin
          found = 0;
          for (int i = 0; i < blk_len && !found; i++) begin
            if (blk_list[i].id == id) begin
              found = 1;
              e = blk_list[i];
              for (int j = i; j + 1 < blk_len; j++) blk_list[j] = blk_list[j+1];
              blk_len--;
              rdy_insert(e);
            end
          end
          r.status = found ? ST_OK : ST_NOTFOUND;
        end
      end
      default: r.status = ST_BADCMD;
    endcase
    if (r.status != ST_BADCMD) begin
      if (run_flag) begin
        if (run_task.ttime == 0) begin
          r.terminated_valid = 1;
          r.terminated_id = run_task.id;
        end else begin
          e = run_task;
          if (e.pri > 0) e.pri--;
          rdy_insert(e);
        end
        run_flag = 0;
        run_task = '0;
      end
      if (rdy_len > 0) begin
        e = rdy_list[0];
        for (int i = 0; i + 1 < rdy_len; i++) rdy_list[i] = rdy_list[i+1];
        rdy_len--;
        if (e.ttime > 0) e.ttime--;
        run_task = e;
        run_flag = 1;
      end
    end
    r.running_valid = run_flag;
    if (run_flag) begin
      r.running_id = run_task.id;
      r.running_priority = run_task.pri;
      r.running_time_left = run_task.ttime;
    end
    r.ready_count = rdy_len[4:0];
    r.blocked_count = blk_len[4:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("result %0d: %s got %0d expected %0d", n_results, field, got, want);
    mismatches++;
  endtask

  // result checker
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      sched_res_t g, w;
      g = out_tdata;
      if (pending_res.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        w = pending_res.pop_front();
        if (g.status != w.status) report_mismatch("status", g.status, w.status);
        if (g.running_valid != w.running_valid)
          report_mismatch("running_valid", g.running_valid, w.running_valid);
        if (g.running_id != w.running_id)
          report_mismatch("running_id", g.running_id, w.running_id);
        if (g.running_priority != w.running_priority)
          report_mismatch("running_priority", g.running_priority, w.running_priority);
        if (g.running_time_left != w.running_time_left)
          report_mismatch("running_time_left", g.running_time_left, w.running_time_left);
        if (g.terminated_valid != w.terminated_valid)
          report_mismatch("terminated_valid", g.terminated_valid, w.terminated_valid);
        if (g.terminated_id != w.terminated_id)
          report_mismatch("terminated_id", g.terminated_id, w.terminated_id);
        if (g.ready_count != w.ready_count)
          report_mismatch("ready_count", g.ready_count, w.ready_count);
        if (g.blocked_count != w.blocked_count)
          report_mismatch("blocked_count", g.blocked_count, w.blocked_count);
      end
      n_results <= n_results + 1;
    end
  end

  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("priority_process_scheduler_unit: mismatch");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off to back the block up
  initial begin
    int  burst;
    bit  held;
    held = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && n_accepted >= 150) begin
        held = 1;
        out_tready = 1'b0;
        repeat (600) @(negedge clk);
      end
      if (!tail_phase && $urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        burst = $urandom_range(1, 5);
        repeat (burst - 1) @(negedge clk);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  task automatic send_cmd(logic [2:0] cmd, logic [7:0] id, logic [7:0] pri, logic [15:0] tm,
                          bit typed, sched_res_t typed_res);
    sched_res_t r;
    int         gap;
    if (!tail_phase && $urandom_range(0, 4) == 0) begin
      in_tvalid = 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {5'b0, tm, pri, id, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = sched_step(cmd, id, pri, tm);
    pending_res.push_back(typed ? typed_res : r);
    n_accepted++;
    @(negedge clk);
  endtask

  cmd_row_t dir_rows[$];

  initial begin
    sched_res_t big, none;
    int         pick;
    logic [2:0] c;
    logic [7:0] id, pri;
    logic [15:0] tm;
    rdy_len = 0; blk_len = 0; run_task = '0; run_flag = 0;
    none = '0;
    big = '0;
    big.running_valid = 1;
    big.running_priority = 8'hff;
    big.running_time_left = 16'hfffe;

    dir_rows.push_back('{CMD_TICK, 8'd0, 8'd0, 16'd0, 1, '0});
    none.status = ST_NORUN;
    dir_rows.push_back('{CMD_KILL, 8'd0, 8'd0, 16'd0, 1, none});
    dir_rows.push_back('{CMD_BLOCK, 8'd0, 8'd0, 16'd0, 1, none});
    none.status = ST_BLKEMPTY;
    dir_rows.push_back('{CMD_WAKE, 8'd3, 8'd0, 16'd0, 1, none});
    none.status = ST_BADCMD;
    dir_rows.push_back('{3'd5, 8'hff, 8'hff, 16'hffff, 1, none});
    dir_rows.push_back('{3'd7, 8'h00, 8'h00, 16'h0000, 1, none});
    dir_rows.push_back('{CMD_CREATE, 8'd0, 8'hff, 16'hffff, 1, big});
    dir_rows.push_back('{CMD_CREATE, 8'd0, 8'd1, 16'd1, 0, '0});
    dir_rows.push_back('{CMD_CREATE, 8'hff, 8'd0, 16'd0, 0, '0});
    dir_rows.push_back('{CMD_CREATE, 8'd5, 8'hff, 16'd0, 0, '0});
    dir_rows.push_back('{CMD_CREATE, 8'd6, 8'hfe, 16'd3, 0, '0});
    dir_rows.push_back('{CMD_TICK, 8'd0, 8'd0, 16'd0, 0, '0});
    dir_rows.push_back('{CMD_BLOCK, 8'd0, 8'd0, 16'd0, 0, '0});
    dir_rows.push_back('{CMD_BLOCK, 8'd0, 8'd0, 16'd0, 0, '0});
    dir_rows.push_back('{CMD_WAKE, 8'd77, 8'd0, 16'd0, 0, '0});
    dir_rows.push_back('{CMD_WAKE, 8'd0, 8'd0, 16'd0, 0, '0});
    dir_rows.push_back('{CMD_KILL, 8'd0, 8'd0, 16'd0, 0, '0});
    dir_rows.push_back('{3'd6, 8'd1, 8'd1, 16'd1, 0, '0});
    dir_rows.push_back('{CMD_TICK, 8'd0, 8'd0, 16'd0, 0, '0});
    dir_rows.push_back('{CMD_TICK, 8'd0, 8'd0, 16'd0, 0, '0});

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[k])
      send_cmd(dir_rows[k].cmd, dir_rows[k].id, dir_rows[k].pri, dir_rows[k].tm,
               dir_rows[k].typed, dir_rows[k].res);

    for (int n = 0; n < NRand; n++) begin
      if (n >= NRand - 50) tail_phase = 1;
      pick = $urandom_range(0, 99);
      id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 19));
      pri = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
      tm = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
      if (pick < 40) c = CMD_CREATE;
      else if (pick < 52) c = CMD_TICK;
      else if (pick < 62) c = CMD_KILL;
      else if (pick < 77) c = CMD_BLOCK;
      else if (pick < 95) begin
        c = CMD_WAKE;
        if (blk_len > 0 && $urandom_range(0, 3) != 0)
          id = blk_list[$urandom_range(0, blk_len - 1)].id;
      end else c = 3'($urandom_range(5, 7));
      send_cmd(c, id, pri, tm, 0, '0);
    end
    in_tvalid = 1'b0;

    while (pending_res.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_res.size() == 0) begin
      $display("priority_process_scheduler_unit: match");
    end else begin
      $display("priority_process_scheduler_unit: mismatch");
    end
    $finish;
  end
endmodule

### sim.f
hdl/pps_pkg.sv
hdl/pps_list.sv
hdl/priority_process_scheduler_unit.sv
hdl/pps_checker.sv
test/tb.sv
